// ===== design/plc_asp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and character-class helpers for the address string parser.
// No dependencies; used by every module of plc_address_string_parser.
package plc_asp_pkg;

  localparam int unsigned CharWidth = 8;
  localparam int unsigned AddrWidth = 32;
  localparam int unsigned BitWidth  = 4;
  localparam int unsigned NumLetters = 3;

  localparam logic [CharWidth-1:0] CharNul  = 8'h00;
  localparam logic [CharWidth-1:0] CharDot  = 8'h2E;
  localparam logic [CharWidth-1:0] CharZero = 8'h30;
  localparam logic [CharWidth-1:0] CaseBit  = 8'h20;
  localparam logic [7:0]           BitMax   = 8'd15;

  // One parsed address, as delivered on the result channel
  typedef struct packed {
    logic                 parse_error;
    logic [CharWidth-1:0] letter_first;
    logic [CharWidth-1:0] letter_second;
    logic [CharWidth-1:0] letter_third;
    logic [AddrWidth-1:0] word_address;
    logic [BitWidth-1:0]  bit_number;
  } result_t;

  // Space, TAB, LF, VT, FF, CR
  function automatic logic is_ws(input logic [CharWidth-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [CharWidth-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CharWidth-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Fold a letter to upper case (input known to be a letter)
  function automatic logic [CharWidth-1:0] to_upper(input logic [CharWidth-1:0] c);
    return (c >= 8'h61) ? (c - CaseBit) : c;
  endfunction

endpackage

// ===== design/plc_address_string_parser.sv =====
`timescale 1ns / 1ps
// Address string parser (e.g. "H82.1"), one character per input beat.
// Depends on plc_asp_pkg, plc_asp_parse, plc_asp_out.
//
// Input channel: character with in_valid / in_stall. Each beat carries one
// ASCII character; a zero character terminates the string.
// Output channel: one result beat per terminator with out_valid / out_stall:
// parse_error, three upper-case area letters, word_address, bit_number.
// All fields other than parse_error read zero when parse_error is set.
// A character goes from the input register to the parser state update
// (one multiply-by-ten as shift-add); a terminator's result is loaded into
// the result register. Throughput: one character per cycle while in_stall
// is low. in_stall rises only when a terminator waits in the input register
// while the result register still holds an untaken beat, so a stalled
// receiver backs up the input channel one terminator later.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the leading-whitespace state.
module plc_address_string_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [plc_asp_pkg::CharWidth-1:0]  character,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               parse_error,
  output logic [plc_asp_pkg::CharWidth-1:0]  area_letter_first,
  output logic [plc_asp_pkg::CharWidth-1:0]  area_letter_second,
  output logic [plc_asp_pkg::CharWidth-1:0]  area_letter_third,
  output logic [plc_asp_pkg::AddrWidth-1:0]  word_address,
  output logic [plc_asp_pkg::BitWidth-1:0]   bit_number
);

  logic                              full;
  logic [plc_asp_pkg::CharWidth-1:0] char_q;
  logic                              take;
  logic                              res_valid;
  logic                              res_ready;
  plc_asp_pkg::result_t              res;
  plc_asp_pkg::result_t              out_data;

  // Input register: refills whenever its beat is consumed or it is empty
  assign in_stall = full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      char_q <= character;
    end
  end

  plc_asp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (full),
    .beat_char  (char_q),
    .res_ready  (res_ready),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  plc_asp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .stall     (out_stall),
    .ready     (res_ready),
    .valid     (out_valid),
    .data      (out_data)
  );

  assign parse_error        = out_data.parse_error;
  assign area_letter_first  = out_data.letter_first;
  assign area_letter_second = out_data.letter_second;
  assign area_letter_third  = out_data.letter_third;
  assign word_address       = out_data.word_address;
  assign bit_number         = out_data.bit_number;

endmodule

// ===== design/plc_asp_parse.sv =====
`timescale 1ns / 1ps
// Parser state and per-character next-state logic; builds the result on NUL.
// Depends on plc_asp_pkg.
module plc_asp_parse (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                beat_valid,
  input  logic [plc_asp_pkg::CharWidth-1:0]   beat_char,
  input  logic                                res_ready,
  output logic                                take,
  output logic                                res_valid,
  output plc_asp_pkg::result_t                res
);

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_LETTER = 3'd1;
  localparam logic [2:0] PH_MIDWS  = 3'd2;
  localparam logic [2:0] PH_MAIN   = 3'd3;
  localparam logic [2:0] PH_BIT    = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  logic [2:0] phase, phase_next;
  logic [1:0] letter_count, letter_count_next;
  logic [plc_asp_pkg::CharWidth-1:0] letters [plc_asp_pkg::NumLetters];
  logic [plc_asp_pkg::CharWidth-1:0] letters_next [plc_asp_pkg::NumLetters];
  logic [plc_asp_pkg::AddrWidth-1:0] main_acc, main_acc_next;
  logic [plc_asp_pkg::BitWidth-1:0]  bit_acc, bit_acc_next;
  logic bit_overflow, bit_overflow_next;
  logic error_seen, error_seen_next;

  logic                               is_nul;
  logic                               ok;
  logic [plc_asp_pkg::BitWidth-1:0]   digit;
  logic [plc_asp_pkg::AddrWidth-1:0]  main_times_ten;
  logic [7:0]                         bit_sum;

  // A NUL beat needs room in the result register; others always go through
  assign is_nul    = (beat_char == plc_asp_pkg::CharNul);
  assign take      = beat_valid && (!is_nul || res_ready);
  assign res_valid = take && is_nul;

  assign digit = plc_asp_pkg::BitWidth'(beat_char - plc_asp_pkg::CharZero);
  assign main_times_ten = {main_acc[plc_asp_pkg::AddrWidth-4:0], 3'b000} +
                          {main_acc[plc_asp_pkg::AddrWidth-2:0], 1'b0};
  assign bit_sum = {4'd0, bit_acc} * 8'd10 + {4'd0, digit};

  // Result fields are forced to zero when the string did not parse
  assign ok = ((phase == PH_MAIN) || (phase == PH_BIT)) && !error_seen && !bit_overflow;
  always_comb begin
    res.parse_error   = !ok;
    res.letter_first  = ok ? letters[0] : '0;
    res.letter_second = ok ? letters[1] : '0;
    res.letter_third  = ok ? letters[2] : '0;
    res.word_address  = ok ? main_acc : '0;
    res.bit_number    = ok ? bit_acc : '0;
  end

  // Per-character state update
  always_comb begin
    phase_next        = phase;
    letter_count_next = letter_count;
    letters_next      = letters;
    main_acc_next     = main_acc;
    bit_acc_next      = bit_acc;
    bit_overflow_next = bit_overflow;
    error_seen_next   = error_seen;
    unique case (phase)
      PH_LEAD, PH_LETTER: begin
        if (plc_asp_pkg::is_alpha(beat_char)) begin
          if (letter_count != 2'd3) begin
            letters_next[letter_count] = plc_asp_pkg::to_upper(beat_char);
            letter_count_next = letter_count + 2'd1;
            phase_next = PH_LETTER;
          end else begin
            phase_next = PH_ERROR;
            error_seen_next = 1'b1;
          end
        end else if (plc_asp_pkg::is_ws(beat_char)) begin
          if (phase == PH_LETTER) phase_next = PH_MIDWS;
        end else if (plc_asp_pkg::is_digit(beat_char)) begin
          main_acc_next = {28'd0, digit};
          phase_next = PH_MAIN;
        end else begin
          phase_next = PH_ERROR;
          error_seen_next = 1'b1;
        end
      end
      PH_MIDWS: begin
        if (plc_asp_pkg::is_digit(beat_char)) begin
          main_acc_next = {28'd0, digit};
          phase_next = PH_MAIN;
        end else if (!plc_asp_pkg::is_ws(beat_char)) begin
          phase_next = PH_ERROR;
          error_seen_next = 1'b1;
        end
      end
      PH_MAIN: begin
        if (plc_asp_pkg::is_digit(beat_char)) begin
          main_acc_next = main_times_ten + {28'd0, digit};
        end else if (beat_char == plc_asp_pkg::CharDot) begin
          phase_next = PH_BIT;
        end else begin
          phase_next = PH_ERROR;
          error_seen_next = 1'b1;
        end
      end
      PH_BIT: begin
        if (plc_asp_pkg::is_digit(beat_char)) begin
          if (!bit_overflow) begin
            if (bit_sum > plc_asp_pkg::BitMax) bit_overflow_next = 1'b1;
            else bit_acc_next = bit_sum[plc_asp_pkg::BitWidth-1:0];
          end
        end else begin
          phase_next = PH_ERROR;
          error_seen_next = 1'b1;
        end
      end
      default: begin
        phase_next = PH_ERROR;
        error_seen_next = 1'b1;
      end
    endcase
  end

  // State registers; a NUL returns everything to the reset state
  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      phase        <= PH_LEAD;
      letter_count <= '0;
      letters      <= '{default: '0};
      main_acc     <= '0;
      bit_acc      <= '0;
      bit_overflow <= 1'b0;
      error_seen   <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      letter_count <= letter_count_next;
      letters      <= letters_next;
      main_acc     <= main_acc_next;
      bit_acc      <= bit_acc_next;
      bit_overflow <= bit_overflow_next;
      error_seen   <= error_seen_next;
    end
  end

`ifndef SYNTH
  a_error_phase_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR) |-> error_seen)
    else $error("error phase without error flag");
  a_letter_phase_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LETTER) |-> (letter_count != 2'd0))
    else $error("letter phase with no letters");
  a_overflow_phase: assert property (@(posedge clk) disable iff (rst)
    bit_overflow |-> ((phase == PH_BIT) || (phase == PH_ERROR)))
    else $error("bit overflow outside bit field");
  a_nul_resets: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> ((phase == PH_LEAD) && (letter_count == 2'd0) && !error_seen))
    else $error("parser not cleared after terminator");
`endif

endmodule

// ===== design/plc_asp_out.sv =====
`timescale 1ns / 1ps
// Result register for the output channel; holds a beat while stalled.
// Depends on plc_asp_pkg.
module plc_asp_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  plc_asp_pkg::result_t load_data,
  input  logic                 stall,
  output logic                 ready,
  output logic                 valid,
  output plc_asp_pkg::result_t data
);

  // Free when empty or when the held beat leaves this cycle
  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      data <= load_data;
    end
  end

endmodule

// ===== tb/plc_asp_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for plc_address_string_parser: watches both channels,
// parses the accepted characters itself and compares every result beat.
// Depends on plc_asp_pkg for widths, character codes and result_t.
module plc_asp_result_checker
  import plc_asp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CharWidth-1:0] character,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 parse_error,
  input  logic [CharWidth-1:0] area_letter_first,
  input  logic [CharWidth-1:0] area_letter_second,
  input  logic [CharWidth-1:0] area_letter_third,
  input  logic [AddrWidth-1:0] word_address,
  input  logic [BitWidth-1:0]  bit_number,
  output int                   fail_count,
  output int                   results_pending,
  output int                   results_seen,
  output int                   rejects_seen
);

  // Character codes used by the grammar
  localparam logic [CharWidth-1:0] ChSpace = 8'h20;
  localparam logic [CharWidth-1:0] ChTab   = 8'h09;
  localparam logic [CharWidth-1:0] ChCr    = 8'h0D;
  localparam logic [CharWidth-1:0] ChNine  = 8'h39;
  localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
  localparam logic [CharWidth-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharWidth-1:0] ChLowA  = 8'h61;
  localparam logic [CharWidth-1:0] ChLowZ  = 8'h7A;

  typedef enum logic [2:0] {
    ScanLead, ScanName, ScanGap, ScanWord, ScanBit, ScanBad
  } scan_t;

  // Parser state as predicted from the accepted characters
  scan_t                scan;
  logic [1:0]           name_len;
  logic [CharWidth-1:0] name [NumLetters];
  logic [AddrWidth-1:0] word_acc;
  logic [BitWidth-1:0]  bit_acc;
  logic                 bit_ovf;
  logic                 bad;

  result_t parsed_q[$];
  int      errors = 0;
  int      seen = 0;
  int      rejected = 0;

  task automatic clear_scan();
    scan     = ScanLead;
    name_len = '0;
    foreach (name[i]) name[i] = '0;
    word_acc = '0;
    bit_acc  = '0;
    bit_ovf  = 1'b0;
    bad      = 1'b0;
  endtask

  task automatic report(input string msg);
    errors++;
    $display("%0t ns MISMATCH: %s", $time, msg);
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", what, got, want));
  endtask

  // Advance the predicted parser by one character; a NUL queues a result
  task automatic scan_char(input logic [CharWidth-1:0] c);
    result_t              want;
    logic                 ok;
    logic                 is_digit;
    logic                 is_space;
    logic                 is_letter;
    logic [CharWidth-1:0] digit;
    logic [7:0]           bit_next;
    is_digit  = (c >= CharZero) && (c <= ChNine);
    is_space  = (c == ChSpace) || (c >= ChTab && c <= ChCr);
    is_letter = (c >= ChUpA && c <= ChUpZ) || (c >= ChLowA && c <= ChLowZ);
    digit     = c - CharZero;
    if (c == CharNul) begin
      ok = (scan == ScanWord || scan == ScanBit) && !bad && !bit_ovf;
      want = '0;
      want.parse_error = !ok;
      if (ok) begin
        want.letter_first  = name[0];
        want.letter_second = name[1];
        want.letter_third  = name[2];
        want.word_address  = word_acc;
        want.bit_number    = bit_acc;
      end
      parsed_q.push_back(want);
      clear_scan();
    end else begin
      case (scan)
        ScanLead, ScanName: begin
          if (is_letter) begin
            if (name_len < 2'(NumLetters)) begin
              name[name_len] = (c >= ChLowA) ? c - CaseBit : c;
              name_len++;
              scan = ScanName;
            end else begin
              bad  = 1'b1;
              scan = ScanBad;
            end
          end else if (is_space) begin
            if (scan == ScanName) scan = ScanGap;
          end else if (is_digit) begin
            word_acc = AddrWidth'(digit);
            scan     = ScanWord;
          end else begin
            bad  = 1'b1;
            scan = ScanBad;
          end
        end
        ScanGap: begin
          if (is_digit) begin
            word_acc = AddrWidth'(digit);
            scan     = ScanWord;
          end else if (!is_space) begin
            bad  = 1'b1;
            scan = ScanBad;
          end
        end
        ScanWord: begin
          if (is_digit) begin
            word_acc = word_acc * 32'd10 + AddrWidth'(digit);
          end else if (c == CharDot) begin
            scan = ScanBit;
          end else begin
            bad  = 1'b1;
            scan = ScanBad;
          end
        end
        ScanBit: begin
          if (is_digit) begin
            // bit number freezes once it has gone past the limit
            if (!bit_ovf) begin
              bit_next = {4'b0, bit_acc} * 8'd10 + digit;
              if (bit_next > BitMax) bit_ovf = 1'b1;
              else bit_acc = bit_next[BitWidth-1:0];
            end
          end else begin
            bad  = 1'b1;
            scan = ScanBad;
          end
        end
        default: begin
          bad  = 1'b1;
          scan = ScanBad;
        end
      endcase
    end
  endtask

  // Compare one result beat with the oldest prediction
  task automatic check_beat();
    result_t want;
    if (parsed_q.size() == 0) begin
      report("result beat with no string terminated");
    end else begin
      want = parsed_q.pop_front();
      seen++;
      if (want.parse_error) rejected++;
      compare_field("parse_error", parse_error, want.parse_error);
      compare_field("area_letter_first", area_letter_first, want.letter_first);
      compare_field("area_letter_second", area_letter_second, want.letter_second);
      compare_field("area_letter_third", area_letter_third, want.letter_third);
      compare_field("word_address", word_address, want.word_address);
      compare_field("bit_number", bit_number, want.bit_number);
    end
  endtask

  // Output side first, then the character accepted at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      parsed_q.delete();
    end else begin
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) scan_char(character);
    end
    fail_count      <= errors;
    results_pending <= parsed_q.size();
    results_seen    <= seen;
    rejects_seen    <= rejected;
  end

endmodule

// ===== tb/tb_plc_address_string_parser.sv =====
`timescale 1ns / 1ps
// Testbench top for plc_address_string_parser: clock, reset, character
// stimulus and random stalls; checking is done by plc_asp_result_checker.
// Depends on plc_asp_pkg, the parser RTL and tb/plc_asp_result_checker.sv.
module tb_plc_address_string_parser;
  import plc_asp_pkg::*;

  localparam int CharsPerPhase = 450;
  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 4;
  localparam int ResetCycles   = 4;

  localparam logic [CharWidth-1:0] ChSpace = 8'h20;
  localparam logic [CharWidth-1:0] ChTab   = 8'h09;
  localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
  localparam logic [CharWidth-1:0] CharTop = 8'hFF;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [CharWidth-1:0] character = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 parse_error;
  logic [CharWidth-1:0] area_letter_first;
  logic [CharWidth-1:0] area_letter_second;
  logic [CharWidth-1:0] area_letter_third;
  logic [AddrWidth-1:0] word_address;
  logic [BitWidth-1:0]  bit_number;

  int fail_count;
  int results_pending;
  int results_seen;
  int rejects_seen;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int chars_sent         = 0;
  int quiet_cycles       = 0;

  logic [CharWidth-1:0] text[$];

  always #6 clk = ~clk;

  plc_address_string_parser uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .character          (character),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .parse_error        (parse_error),
    .area_letter_first  (area_letter_first),
    .area_letter_second (area_letter_second),
    .area_letter_third  (area_letter_third),
    .word_address       (word_address),
    .bit_number         (bit_number)
  );

  plc_asp_result_checker result_check (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .character          (character),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .parse_error        (parse_error),
    .area_letter_first  (area_letter_first),
    .area_letter_second (area_letter_second),
    .area_letter_third  (area_letter_third),
    .word_address       (word_address),
    .bit_number         (bit_number),
    .fail_count         (fail_count),
    .results_pending    (results_pending),
    .results_seen       (results_seen),
    .rejects_seen       (rejects_seen)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < receiver_stall_pct);
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send every queued character, one beat each, with random sender gaps
  task automatic send_text();
    logic [CharWidth-1:0] c;
    while (text.size() != 0) begin
      c = text.pop_front();
      while ($urandom_range(99) < sender_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid  <= 1'b1;
      character <= c;
      do @(posedge clk); while (in_stall);
      chars_sent++;
    end
  endtask

  task automatic push_chars(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic send_line(input string s);
    push_chars(s);
    text.push_back(CharNul);
    send_text();
  endtask

  task automatic push_space();
    int pick;
    pick = $urandom_range(6);
    text.push_back((pick == 6) ? ChSpace : ChTab + CharWidth'(pick % 5));
  endtask

  task automatic push_letter();
    logic [CharWidth-1:0] c;
    c = ChUpA + CharWidth'($urandom_range(25));
    if ($urandom_range(1)) c = c + CaseBit;
    text.push_back(c);
  endtask

  task automatic push_digit();
    text.push_back(CharZero + CharWidth'($urandom_range(9)));
  endtask

  // Main address: mostly short, some long enough to wrap, some at the edge
  task automatic push_number();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0: push_chars("4294967295");
        1: push_chars("4294967296");
        2: push_chars("0");
        default: push_chars("99999999999");
      endcase
    end else if (pick < 3) begin
      repeat ($urandom_range(12, 8)) push_digit();
    end else begin
      repeat ($urandom_range(4, 1)) push_digit();
    end
  endtask

  // One random string: mostly well-formed, some with a fourth letter or a
  // corrupted character, some plain noise
  task automatic build_string();
    int kind;
    int letters;
    int spot;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(8)) text.push_back(CharWidth'($urandom_range(255, 1)));
    end else begin
      repeat ($urandom_range(2)) push_space();
      letters = (kind >= 75) ? 4 : $urandom_range(3);
      repeat (letters) push_letter();
      repeat ($urandom_range(2)) push_space();
      push_number();
      if ($urandom_range(1)) begin
        text.push_back(CharDot);
        case ($urandom_range(4))
          0: ;
          1: push_chars("15");
          2: push_chars("16");
          default: repeat ($urandom_range(3, 1)) push_digit();
        endcase
      end
      if (kind >= 65 && kind < 75) begin
        spot = $urandom_range(text.size() - 1);
        text[spot] = CharWidth'($urandom_range(255, 1));
      end
    end
    text.push_back(CharNul);
  endtask

  // Hold the sender off until every terminated string has its result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target = chars_sent + CharsPerPhase;
    while (chars_sent < target) begin
      build_string();
      send_text();
    end
    drain();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings: lower case with leading blank, empty string,
    // fourth letter, letter after whitespace, bare dot, bit overflow,
    // top character code
    send_line(" h82.1");
    send_line("");
    send_line("ABCD");
    send_line("D\tX");
    send_line("7.");
    send_line("1.16");
    text.push_back(CharTop);
    send_line("");
    drain();

    run_phase(0, 0);
    run_phase(82, 0);
    run_phase(0, 82);
    run_phase(25, 25);

    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d characters; %0d results checked, %0d of them rejected strings,",
             chars_sent, results_seen, rejects_seen);
    $display("under free-running, sender-gap, receiver-stall and mixed pacing.");
    if (fail_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
